### hw/rtl/sorted_value_table_top_defines.svh
// ---------------------------------------------------------------------------
// sorted value table assertion macros
// shared property shapes for the port checker
// ---------------------------------------------------------------------------
`ifndef SORTED_VALUE_TABLE_TOP_DEFINES_SVH
`define SORTED_VALUE_TABLE_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted value table check failed");

// next-cycle implication, quiet during reset
`define SVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted value table check failed");

`endif

### hw/rtl/svt_pkg.sv
// ---------------------------------------------------------------------------
// sorted value table package
// widths, operation and status codes, cell control types
// ---------------------------------------------------------------------------
package svt_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int VAL_W        = 32;
  localparam int OP_W         = 2;
  localparam int POS_W        = 4;
  localparam int ST_W         = 2;
  localparam int CNT_OUT_W    = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd3;

  typedef logic signed [VAL_W-1:0] svt_val_t;

  // broadcast to every cell
  typedef struct packed {
    logic     ins_en;
    logic     rem_en;
    svt_val_t value;
  } svt_ctl_t;

  // per-cell compare results
  typedef struct packed {
    logic le;
    logic ge;
    logic match;
  } svt_flags_t;

endpackage

### hw/rtl/svt_in_if.sv
// ---------------------------------------------------------------------------
// sorted value table input channel
// valid/ready channel carrying one operation item
// ---------------------------------------------------------------------------
interface svt_in_if import svt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  svt_val_t        value;
  logic [POS_W-1:0] position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink (input valid, input operation, input value, input position,
                output ready);
endinterface

### hw/rtl/svt_out_if.sv
// ---------------------------------------------------------------------------
// sorted value table result channel
// valid/ready channel carrying one result item
// ---------------------------------------------------------------------------
interface svt_out_if import svt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ST_W-1:0]      status;
  svt_val_t             read_value;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink (input valid, input status, input read_value, input entry_count,
                output ready);
endinterface

### hw/rtl/sorted_value_table_top.sv
// ---------------------------------------------------------------------------
// sorted value table
// ascending table of signed values kept in a row of compare/shift cells
// ---------------------------------------------------------------------------
// in_ch carries one item: operation (insert, remove, read), value, position.
// out_ch returns exactly one result item per input item: status, read_value
// (entry for a good read, else zero) and entry_count after the operation.
// every cell compares its entry with the broadcast value in the same cycle
// and loads its own entry, the broadcast value, its left or its right
// neighbor, so an insert or a remove updates the whole row at once.
// the result is registered and appears in the cycle after the item is accepted.
// throughput: one item per cycle while out_ch is taken; a new item is taken
// in the cycle the held result leaves.
// when out_ch stalls the result register holds and in_ch.ready drops.
// reset clears the entry count and the result valid; entry storage is not
// cleared, slots at or above the count are never read.
// insert into a full table reports full and drops the value; remove of an
// absent value reports not found; read past the count reports out of range.
// ---------------------------------------------------------------------------
module sorted_value_table_top import svt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  svt_in_if.sink    in_ch,
  svt_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]      status_r, status_nxt;
  svt_val_t             read_value_r, read_value_nxt;
  logic [CNT_OUT_W-1:0] out_count_r;

  svt_val_t             entries [CAPACITY];
  svt_flags_t           flags   [CAPACITY];
  logic [CAPACITY-1:0]  match_vec;
  svt_ctl_t             ctl;

  logic     accept;
  logic     full;
  logic     found;
  logic     rd_hit;
  svt_val_t rd_data;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = count_r == CNT_W'(CAPACITY);
  assign found       = |match_vec;

  assign ctl.value  = in_ch.value;
  assign ctl.ins_en = accept && (in_ch.operation == OP_INSERT) && !full;
  assign ctl.rem_en = accept && (in_ch.operation == OP_REMOVE) && found;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      svt_val_t left_entry, right_entry;
      logic     left_le;

      if (gi == 0) begin : g_first
        assign left_entry = '0;
        assign left_le    = 1'b1;
      end else begin : g_mid
        assign left_entry = entries[gi-1];
        assign left_le    = flags[gi-1].le;
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_entry = '0;
      end else begin : g_inner
        assign right_entry = entries[gi+1];
      end

      assign match_vec[gi] = flags[gi].match;

      svt_cell #(.CAPACITY(CAPACITY), .IDX(gi)) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .count       (count_r),
        .left_entry  (left_entry),
        .left_le     (left_le),
        .right_entry (right_entry),
        .entry       (entries[gi]),
        .flags       (flags[gi])
      );
    end
  endgenerate

  // only the first positions are addressable
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (in_ch.position == POS_W'(i)) begin
        rd_data = entries[i];
      end
    end
  end

  assign rd_hit = CMP_W'(in_ch.position) < CMP_W'(count_r);

  always_comb begin
    count_nxt      = count_r;
    status_nxt     = ST_OK;
    read_value_nxt = '0;
    case (in_ch.operation)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_MISSING;
        end
      end
      OP_READ: begin
        if (rd_hit) begin
          read_value_nxt = rd_data;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      read_value_r <= read_value_nxt;
      out_count_r  <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.read_value  = read_value_r;
  assign out_ch.entry_count = out_count_r;

endmodule

### hw/rtl/svt_cell.sv
// ---------------------------------------------------------------------------
// sorted value table cell
// holds one entry, compares it with the broadcast value and shifts
// ---------------------------------------------------------------------------
module svt_cell import svt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int IDX      = 0
) (
  input  logic                             clk,
  input  svt_ctl_t                         ctl,
  input  logic [$clog2(CAPACITY+1)-1:0]    count,
  input  svt_val_t                         left_entry,
  input  logic                             left_le,
  input  svt_val_t                         right_entry,
  output svt_val_t                         entry,
  output svt_flags_t                       flags
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  svt_val_t entry_r, entry_nxt;
  logic     valid;

  assign valid       = count > CNT_W'(IDX);
  assign flags.le    = valid && (entry_r <= ctl.value);
  assign flags.ge    = valid && (entry_r >= ctl.value);
  assign flags.match = valid && (entry_r == ctl.value);
  assign entry       = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en) begin
      // cells past the insertion point take their left neighbor
      if (!left_le) begin
        entry_nxt = left_entry;
      end else if (!flags.le) begin
        entry_nxt = ctl.value;
      end
    end else if (ctl.rem_en && flags.ge) begin
      // first equal entry onward closes the gap from the right
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### hw/rtl/svt_checker.sv
// ---------------------------------------------------------------------------
// sorted value table port checker
// watches the channels of the top level over time
// ---------------------------------------------------------------------------
`include "sorted_value_table_top_defines.svh"

module svt_checker import svt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [ST_W-1:0]      out_status,
  input svt_val_t             out_read_value,
  input logic [CNT_OUT_W-1:0] out_entry_count
);

  // every accepted item yields a result on the next cycle
  `SVT_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid)

  // a stalled result holds its value
  `SVT_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_status) && $stable(out_read_value)
                   && $stable(out_entry_count))

  // failed operations return no data
  `SVT_ASSERT_NOW(a_fail_no_data, clk, rst_n, out_valid && (out_status != ST_OK),
                  out_read_value == '0)

  // full is only reported with the table at capacity
  `SVT_ASSERT_NOW(a_full_count, clk, rst_n, out_valid && (out_status == ST_FULL),
                  out_entry_count == CNT_OUT_W'(CAPACITY))

  // nothing is accepted while a result waits unaccepted
  `SVT_ASSERT_NOW(a_no_overrun, clk, rst_n, out_valid && !out_ready, !in_ready)

endmodule

bind sorted_value_table_top svt_checker #(.CAPACITY(CAPACITY)) u_svt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_read_value  (out_ch.read_value),
  .out_entry_count (out_ch.entry_count)
);
